>>> design/ses_pkg.sv
// shared types and constants of the string literal escape segmenter
package ses_pkg;

   localparam int LINE_BITS   = 20;
   localparam int COLUMN_BITS = 16;
   localparam int LENGTH_BITS = COLUMN_BITS + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOW_X  = 8'h78;
   localparam logic [7:0] CHAR_UP_X   = 8'h58;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_SEVEN  = 8'h37;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CHAR_LOW_F  = 8'h66;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_F   = 8'h46;

   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_CHAR  = 2'd1,
      CMD_END   = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      CLS_OTHER  = 3'd0,
      CLS_QUOTE  = 3'd1,
      CLS_BSLASH = 3'd2,
      CLS_X      = 3'd3,
      CLS_OCT    = 3'd4,
      CLS_HEX    = 3'd5
   } char_class_type;

   typedef enum logic [5:0] {
      MODE_IDLE  = 6'b000001,
      MODE_QUOTE = 6'b000010,
      MODE_BODY  = 6'b000100,
      MODE_ESC   = 6'b001000,
      MODE_HEX   = 6'b010000,
      MODE_OCT   = 6'b100000
   } mode_type;

   typedef struct packed {
      command_type             command;
      char_class_type          char_class;
      logic [LINE_BITS-1:0]    line;
      logic [COLUMN_BITS-1:0]  column;
      logic [COLUMN_BITS-1:0]  value_length;
   } queue_entry_type;

endpackage

>>> design/ses_if.sv
// request and response channel interfaces
interface ses_req_if import ses_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             command;
   logic [7:0]             char_byte;
   logic [LINE_BITS-1:0]   line;
   logic [COLUMN_BITS-1:0] column;
   logic [COLUMN_BITS-1:0] value_length;

   modport source (output valid, command, char_byte, line, column, value_length,
                   input ready);
   modport sink   (input valid, command, char_byte, line, column, value_length,
                   output ready);
endinterface

interface ses_rsp_if import ses_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [LINE_BITS-1:0]   span_line;
   logic [COLUMN_BITS-1:0] span_column;
   logic [LENGTH_BITS-1:0] span_length;
   logic                   is_last;

   modport source (output valid, span_line, span_column, span_length, is_last,
                   input ready);
   modport sink   (input valid, span_line, span_column, span_length, is_last,
                   output ready);
endinterface

>>> design/string_literal_escape_segmenter.sv
// top level of the string literal escape segmenter
//
// req channel: command begin carries line, column and value_length of a
// literal; command char carries one document byte; command end marks the
// end of the document. rsp channel: string spans (line, column, length)
// with is_last on the final span of a literal.
// a request is taken into a four-entry queue whenever the queue has room,
// so req.ready does not depend on rsp.ready directly. the scanner pops one
// request per cycle while rsp is not stalled and loads the response register;
// a request passes through the queue, and its spans through that register.
// a closing quote that ends an open run gives two spans: the run's span,
// then the quote, which stays at the queue head and is replayed.
// when rsp is stalled the response register holds its span, the scanner
// waits and the queue fills, then req.ready drops.
// synchronous reset empties the queue and the response register and puts
// the scanner in idle; no request is taken in the reset cycle.
module string_literal_escape_segmenter
   import ses_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ses_req_if.sink   req,
   ses_rsp_if.source rsp
);

   logic            queue_ready;
   logic            push;
   queue_entry_type push_entry;
   logic            head_valid;
   queue_entry_type head;
   logic            pop;

   ses_front u_front (
      .req         (req),
      .queue_ready (queue_ready),
      .push        (push),
      .entry       (push_entry)
   );

   ses_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .ready      (queue_ready),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   ses_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

>>> design/ses_front.sv
// front end: takes requests and classifies document characters
module ses_front
   import ses_pkg::*;
(
   ses_req_if.sink          req,
   input  logic            queue_ready,
   output logic            push,
   output queue_entry_type entry
);

   function automatic char_class_type classify(input logic [7:0] c);
      char_class_type cls;
      priority if (c == CHAR_QUOTE)                       cls = CLS_QUOTE;
      else if (c == CHAR_BSLASH)                          cls = CLS_BSLASH;
      else if (c == CHAR_LOW_X || c == CHAR_UP_X)         cls = CLS_X;
      else if (c >= CHAR_ZERO && c <= CHAR_SEVEN)         cls = CLS_OCT;
      else if ((c > CHAR_SEVEN && c <= CHAR_NINE) ||
               (c >= CHAR_LOW_A && c <= CHAR_LOW_F) ||
               (c >= CHAR_UP_A && c <= CHAR_UP_F))        cls = CLS_HEX;
      else                                                cls = CLS_OTHER;
      return cls;
   endfunction

   assign req.ready = queue_ready;
   assign push      = req.valid && queue_ready;

   always_comb begin
      entry.command      = command_type'(req.command);
      entry.char_class   = classify(req.char_byte);
      entry.line         = req.line;
      entry.column       = req.column;
      entry.value_length = req.value_length;
   end

endmodule

>>> design/ses_queue.sv
// short request queue between front and back
module ses_queue
   import ses_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   output logic            ready,
   output logic            head_valid,
   output queue_entry_type head,
   input  logic            pop
);

   queue_entry_type        entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;

   assign ready      = !reset && (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule

>>> design/ses_back.sv
// back end: scan state machine and response register
module ses_back
   import ses_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  queue_entry_type head,
   output logic            pop,
   ses_rsp_if.source       rsp
);

   mode_type               mode_ff, mode_in;
   logic                   digit_ff, digit_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [COLUMN_BITS-1:0] run_start_ff, run_start_in;
   logic                   run_open_ff, run_open_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] len_ff, len_in;

   logic                   out_valid_ff, out_valid_in;
   logic [LINE_BITS-1:0]   out_line_ff;
   logic [COLUMN_BITS-1:0] out_col_ff;
   logic [LENGTH_BITS-1:0] out_len_ff;
   logic                   out_last_ff;

   logic                   advance;
   logic                   emit;
   logic [COLUMN_BITS-1:0] e_col;
   logic [LENGTH_BITS-1:0] e_len;
   logic                   e_last;
   logic                   body_go;
   logic                   is_digit;
   logic [COLUMN_BITS-1:0] col_next;
   logic [COLUMN_BITS-1:0] run_len;
   logic [LENGTH_BITS-1:0] run_span;
   logic [LENGTH_BITS-1:0] fallback;

   assign advance  = !out_valid_ff || rsp.ready;
   assign col_next = (col_ff == COL_MAX) ? col_ff : col_ff + COLUMN_BITS'(1);
   assign run_len  = col_ff - run_start_ff;
   assign run_span = (run_len == '0) ? LENGTH_BITS'(1) : {1'b0, run_len};
   assign fallback = {1'b0, len_ff} + LENGTH_BITS'(2);
   assign is_digit = (head.char_class == CLS_OCT) ||
                     (mode_ff == MODE_HEX && head.char_class == CLS_HEX);

   always_comb begin
      mode_in      = mode_ff;
      digit_in     = digit_ff;
      col_in       = col_ff;
      run_start_in = run_start_ff;
      run_open_in  = run_open_ff;
      line_in      = line_ff;
      len_in       = len_ff;
      emit         = 1'b0;
      e_col        = col_ff;
      e_len        = LENGTH_BITS'(1);
      e_last       = 1'b0;
      body_go      = 1'b0;
      pop          = 1'b0;
      if (head_valid && advance) begin
         pop = 1'b1;
         unique case (head.command)
            CMD_BEGIN: begin
               line_in      = head.line;
               col_in       = head.column;
               len_in       = head.value_length;
               run_start_in = '0;
               run_open_in  = 1'b0;
               digit_in     = 1'b0;
               mode_in      = MODE_QUOTE;
            end
            CMD_CHAR: begin
               unique case (mode_ff)
                  MODE_QUOTE: begin
                     emit = 1'b1;
                     if (head.char_class == CLS_QUOTE) begin
                        col_in  = col_next;
                        mode_in = MODE_BODY;
                     end else begin
                        e_len   = fallback;
                        e_last  = 1'b1;
                        mode_in = MODE_IDLE;
                     end
                  end
                  MODE_BODY: begin
                     body_go = 1'b1;
                  end
                  MODE_ESC: begin
                     col_in   = col_next;
                     digit_in = 1'b0;
                     priority if (head.char_class == CLS_X)   mode_in = MODE_HEX;
                     else if (head.char_class == CLS_OCT)     mode_in = MODE_OCT;
                     else                                     mode_in = MODE_BODY;
                  end
                  MODE_HEX, MODE_OCT: begin
                     if (is_digit) begin
                        col_in = col_next;
                        if (digit_ff) begin
                           digit_in = 1'b0;
                           mode_in  = MODE_BODY;
                        end else begin
                           digit_in = 1'b1;
                        end
                     end else begin
                        digit_in = 1'b0;
                        mode_in  = MODE_BODY;
                        body_go  = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            CMD_END: begin
               if (mode_ff == MODE_QUOTE) begin
                  emit   = 1'b1;
                  e_len  = fallback;
                  e_last = 1'b1;
               end else if ((mode_ff == MODE_BODY || mode_ff == MODE_HEX ||
                             mode_ff == MODE_OCT) && run_open_ff) begin
                  emit   = 1'b1;
                  e_col  = run_start_ff;
                  e_len  = run_span;
                  e_last = 1'b1;
               end
               run_open_in = 1'b0;
               digit_in    = 1'b0;
               mode_in     = MODE_IDLE;
            end
            default: begin
            end
         endcase
         if (body_go) begin
            priority if (head.char_class == CLS_QUOTE) begin
               emit = 1'b1;
               if (run_open_ff) begin
                  // close the run now, keep the quote at the queue head to replay it
                  e_col       = run_start_ff;
                  e_len       = run_span;
                  run_open_in = 1'b0;
                  mode_in     = mode_ff;
                  digit_in    = digit_ff;
                  pop         = 1'b0;
               end else begin
                  e_last  = 1'b1;
                  mode_in = MODE_IDLE;
               end
            end else if (head.char_class == CLS_BSLASH) begin
               if (run_open_ff) begin
                  emit        = 1'b1;
                  e_col       = run_start_ff;
                  e_len       = run_span;
                  run_open_in = 1'b0;
               end
               col_in  = col_next;
               mode_in = MODE_ESC;
            end else begin
               if (!run_open_ff) begin
                  run_start_in = col_ff;
                  run_open_in  = 1'b1;
               end
               col_in = col_next;
            end
         end
      end
   end

   assign out_valid_in = advance ? emit : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         digit_ff     <= 1'b0;
         run_open_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         digit_ff     <= digit_in;
         run_open_ff  <= run_open_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      run_start_ff <= run_start_in;
      line_ff      <= line_in;
      len_ff       <= len_in;
      if (advance && emit) begin
         out_line_ff <= line_ff;
         out_col_ff  <= e_col;
         out_len_ff  <= e_len;
         out_last_ff <= e_last;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.span_line   = out_line_ff;
   assign rsp.span_column = out_col_ff;
   assign rsp.span_length = out_len_ff;
   assign rsp.is_last     = out_last_ff;

   a_run_mode: assert property (@(posedge clock) disable iff (reset)
      run_open_ff |-> (mode_ff == MODE_BODY || mode_ff == MODE_HEX ||
                       mode_ff == MODE_OCT))
      else $error("open run outside literal body");

   a_digit_mode: assert property (@(posedge clock) disable iff (reset)
      digit_ff |-> (mode_ff == MODE_HEX || mode_ff == MODE_OCT))
      else $error("escape digit count outside numeric escape");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (pop && emit && e_last) |=> (mode_ff == MODE_IDLE))
      else $error("final span without return to idle");

endmodule
